@@ sv/seeded_hash128_add_rotate_unit_assert.svh @@
// Assertion macros shared by the hash unit.
`ifndef SEEDED_HASH128_ADD_ROTATE_UNIT_ASSERT_SVH
`define SEEDED_HASH128_ADD_ROTATE_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SH128AR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SH128AR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/sh128ar_pkg.sv @@
package sh128ar_pkg;

	localparam logic [63:0] PRIME_0 = 64'h9E3779B185EBCA87;
	localparam logic [63:0] PRIME_1 = 64'hC2B2AE3D27D4EB4F;
	localparam logic [63:0] PRIME_2 = 64'h165667B19E3779F9;
	localparam logic [63:0] PRIME_3 = 64'h85EBCA77C2B2AE63;
	localparam logic [63:0] PRIME_4 = 64'h27D4EB2F165667C5;

	localparam int unsigned ROT_MIX   = 41;
	localparam int unsigned ROT_CROSS = 17;
	localparam int unsigned ROT_LANE  = 32;

	localparam logic [1:0] LANE_A = 2'd0;
	localparam logic [1:0] LANE_B = 2'd1;
	localparam logic [1:0] LANE_C = 2'd2;
	localparam logic [1:0] LANE_D = 2'd3;

	// Operand selection for the shared multiplier.
	typedef enum logic [1:0] {
		MUL_WORD,
		MUL_LO,
		MUL_HI
	} mul_op_t;

	typedef struct packed {
		logic    load;
		logic    mul_start;
		mul_op_t mul_op;
		logic    apply_word;
		logic    apply_part;
		logic    xrot;
		logic    save_lo;
		logic    emit;
	} dp_cmd_t;

	typedef struct packed {
		logic bl_zero;
		logic is_part;
		logic last_word;
		logic mul_done;
		logic out_free;
	} dp_status_t;

	function automatic logic [63:0] rotr64(input logic [63:0] v, input int unsigned s);
		return (v >> s) | (v << (64 - s));
	endfunction

	function automatic logic [63:0] mix41(input logic [63:0] v);
		return v ^ rotr64(v, ROT_MIX);
	endfunction

	function automatic logic [63:0] stripe_prime(input logic [1:0] idx);
		logic [63:0] p;
		unique case (idx)
			LANE_A: p = PRIME_0;
			LANE_B: p = PRIME_1;
			LANE_C: p = PRIME_2;
			default: p = PRIME_3;
		endcase
		return p;
	endfunction

endpackage

@@ sv/seeded_hash128_add_rotate_unit.sv @@
// Channel   Direction  tdata fields (low bit up)                       Handshake
// s_axis    in         word[63:0], total_length[95:64]                  s_tvalid/s_tready
// m_axis    out        hash_low[63:0], hash_high[127:64], hash_sum[191:128]
//                                                                     m_tvalid/m_tready
// cfg       in         seed written from cfg_wdata when cfg_we is high  none
//
// A full word is accepted, decoded and multiplied before the next one is taken:
// one 64x64 product built from three 32x32 partial products on the shared multiplier.
// A partial last word is added without the multiplier; the finish adds two more products.
// An empty message (total_length zero) goes straight to the finish.
// Reset clears the seed, the byte count and the message flag; lanes load at start.
// A held result in the output register does not block the next word, only the next
// result: the finish waits in its last step until m_tready frees the register.
module seeded_hash128_add_rotate_unit import sh128ar_pkg::*; #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // word[63:0], total_length[95:64]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [191:0] m_tdata,   // hash_low[63:0], hash_high[127:64], hash_sum[191:128]
	input  logic         cfg_we,
	input  logic [63:0]  cfg_wdata
);

	dp_cmd_t    cmd;
	dp_status_t status;
	logic [63:0] hash_low, hash_high, hash_sum;

	// Sequence decode, multiply, lane update and finish.
	sh128ar_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Hold lanes, byte count, seed and the output register.
	sh128ar_dpath #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_word   (s_tdata[63:0]),
		.in_length (s_tdata[95:64]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.hash_low  (hash_low),
		.hash_high (hash_high),
		.hash_sum  (hash_sum)
	);

	// Pack the result transaction, lowest field first.
	assign m_tdata = {hash_sum, hash_high, hash_low};

endmodule

@@ sv/sh128ar_mul.sv @@
module sh128ar_mul import sh128ar_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output logic        done,
	output logic [63:0] result
);

	// Low 64 bits of a 64x64 product from three 32x32 partial products.
	logic [63:0] a_q, b_q, prod_q, acc_q;
	logic [1:0]  ph_q;
	logic        busy_q, done_q;
	logic [31:0] mx, my;
	logic [63:0] prod_c;

	always_comb begin
		unique case (ph_q)
			2'd1: begin
				mx = a_q[31:0];
				my = b_q[63:32];
			end
			2'd2: begin
				mx = a_q[63:32];
				my = b_q[31:0];
			end
			default: begin
				mx = a_q[31:0];
				my = b_q[31:0];
			end
		endcase
	end

	assign prod_c = mx * my;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			ph_q   <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end else if (busy_q) begin
			prod_q <= prod_c;
			unique case (ph_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= prod_q;
				default: acc_q <= acc_q + {prod_q[31:0], 32'b0};
			endcase
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

@@ sv/sh128ar_dpath.sv @@
module sh128ar_dpath import sh128ar_pkg::*; #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [63:0] in_word,
	input  logic [31:0] in_length,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [63:0] hash_low,
	output logic [63:0] hash_high,
	output logic [63:0] hash_sum
);

	localparam int LW = LENGTH_WIDTH;

	logic [63:0]   seed_q, word_q, lo_q;
	logic [63:0]   lane_q [4];
	logic [LW-1:0] bytes_left_q;
	logic [1:0]    word_pos_q;
	logic          in_msg_q, out_valid_q;
	logic [63:0]   hash_low_q, hash_high_q, hash_sum_q;

	logic [LW-1:0] len;
	logic [63:0]   len64;
	logic          stripe, bl_lt8;
	logic [1:0]    idx;
	logic [63:0]   part_mask, part, lane_sum, mix_res;
	logic [63:0]   xa, xb, xc, xd;
	logic [63:0]   mul_a, mul_b, mul_res;
	logic          mul_done;

	assign len   = LW'(in_length);
	assign len64 = 64'(len);

	assign stripe = (word_pos_q != 2'd0) || (|bytes_left_q[LW-1:5]);
	assign bl_lt8 = bytes_left_q < LW'(8);
	assign idx    = stripe ? word_pos_q : (bytes_left_q[4:3] - 2'd1);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			part_mask[8*i +: 8] = (3'(i) < bytes_left_q[2:0]) ? 8'hFF : 8'h00;
		end
	end
	assign part = word_q & part_mask;

	assign lane_sum = lane_q[idx] + mul_res;
	assign mix_res  = mix41(mul_res);

	// Cross-rotate the lanes; c and d see the updated a and b.
	assign xa = lane_q[LANE_A] ^ rotr64(lane_q[LANE_C], ROT_CROSS);
	assign xb = lane_q[LANE_B] ^ rotr64(lane_q[LANE_D], ROT_CROSS);
	assign xc = lane_q[LANE_C] ^ rotr64(xa, ROT_CROSS);
	assign xd = lane_q[LANE_D] ^ rotr64(xb, ROT_CROSS);

	always_comb begin
		unique case (cmd.mul_op)
			MUL_LO: begin
				mul_a = lane_q[LANE_A] + lane_q[LANE_B];
				mul_b = PRIME_4;
			end
			MUL_HI: begin
				mul_a = lane_q[LANE_C] + lane_q[LANE_D];
				mul_b = PRIME_0;
			end
			default: begin
				mul_a = word_q;
				mul_b = stripe_prime(idx);
			end
		endcase
	end

	sh128ar_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= '0;
			bytes_left_q <= '0;
			word_pos_q   <= '0;
			in_msg_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			if (cmd.load && !in_msg_q) begin
				bytes_left_q <= len;
				word_pos_q   <= '0;
				in_msg_q     <= 1'b1;
			end
			if (cmd.apply_word) begin
				bytes_left_q <= bytes_left_q - LW'(8);
				if (stripe) begin
					word_pos_q <= word_pos_q + 2'd1;
				end
			end
			if (cmd.apply_part) begin
				bytes_left_q <= '0;
			end
			if (cmd.xrot) begin
				in_msg_q   <= 1'b0;
				word_pos_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= in_word;
			if (!in_msg_q) begin
				lane_q[LANE_A] <= seed_q;
				lane_q[LANE_B] <= len64;
				lane_q[LANE_C] <= rotr64(len64, ROT_CROSS) + seed_q;
				lane_q[LANE_D] <= len64 ^ rotr64(seed_q, ROT_CROSS);
			end
		end
		if (cmd.apply_word) begin
			lane_q[idx] <= stripe ? rotr64(lane_sum, ROT_LANE) : lane_sum;
		end
		if (cmd.apply_part) begin
			if (bytes_left_q[2]) begin
				lane_q[LANE_D] <= lane_q[LANE_D] + part;
			end else begin
				lane_q[LANE_C] <= lane_q[LANE_C] + part;
			end
		end
		if (cmd.xrot) begin
			lane_q[LANE_A] <= xa;
			lane_q[LANE_B] <= xb;
			lane_q[LANE_C] <= xc;
			lane_q[LANE_D] <= xd;
		end
		if (cmd.save_lo) begin
			lo_q <= mix_res;
		end
		if (cmd.emit) begin
			hash_low_q  <= lo_q;
			hash_high_q <= mix_res;
			hash_sum_q  <= lo_q + mix_res;
		end
	end

	assign status.bl_zero   = (bytes_left_q == '0);
	assign status.is_part   = !stripe && bl_lt8;
	assign status.last_word = (bytes_left_q == LW'(8));
	assign status.mul_done  = mul_done;
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign hash_low  = hash_low_q;
	assign hash_high = hash_high_q;
	assign hash_sum  = hash_sum_q;

endmodule

@@ sv/sh128ar_ctrl.sv @@
`include "seeded_hash128_add_rotate_unit_assert.svh"

module sh128ar_ctrl import sh128ar_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_DECIDE = 8'b0000_0010,
		ST_MULW   = 8'b0000_0100,
		ST_FIN    = 8'b0000_1000,
		ST_MIXA   = 8'b0001_0000,
		ST_WAITA  = 8'b0010_0000,
		ST_MIXB   = 8'b0100_0000,
		ST_WAITB  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.mul_op = MUL_WORD;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (status.bl_zero) begin
					state_d = ST_FIN;
				end else if (status.is_part) begin
					cmd.apply_part = 1'b1;
					state_d        = ST_FIN;
				end else begin
					cmd.mul_start = 1'b1;
					state_d       = ST_MULW;
				end
			end
			ST_MULW: begin
				if (status.mul_done) begin
					cmd.apply_word = 1'b1;
					state_d        = status.last_word ? ST_FIN : ST_IDLE;
				end
			end
			ST_FIN: begin
				cmd.xrot = 1'b1;
				state_d  = ST_MIXA;
			end
			ST_MIXA: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = MUL_LO;
				state_d       = ST_WAITA;
			end
			ST_WAITA: begin
				if (status.mul_done) begin
					cmd.save_lo = 1'b1;
					state_d     = ST_MIXB;
				end
			end
			ST_MIXB: begin
				cmd.mul_start = 1'b1;
				cmd.mul_op    = MUL_HI;
				state_d       = ST_WAITB;
			end
			ST_WAITB: begin
				if (status.mul_done && status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	`SH128AR_ASSERT_SAME(a_emit_free, cmd.emit, status.out_free && status.mul_done,
		"result loaded while output register busy or product not ready")
	`SH128AR_ASSERT_NEXT(a_start_clears_done, cmd.mul_start, !status.mul_done,
		"multiplier reports done right after a start")
	`SH128AR_ASSERT_SAME(a_apply_after_mul, cmd.apply_word, status.mul_done && !cmd.apply_part,
		"word applied without a finished product")
	`SH128AR_ASSERT_NEXT(a_load_decide, cmd.load, !in_ready,
		"input taken while a previous transaction is still in progress")

endmodule
